// ===== rtl/brcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// brcrs_pkg
// Shared types, codes and helpers of the blit rectangle setup block.
// ----------------------------------------------------------------------------
package brcrs_pkg;

   typedef enum logic [1:0] {
      ROT_0,
      ROT_90,
      ROT_180,
      ROT_270
   } rot_type;

   typedef enum logic {
      REG_ROTATION,
      REG_SCALE
   } reg_idx_type;

   // width of one queued entry for a given coordinate width
   function automatic int entry_bits(input int cb);
      return 14 * cb + 14;
   endfunction

endpackage

// ===== rtl/brcrs_front.sv =====
// ----------------------------------------------------------------------------
// brcrs_front
// Clips the scissor against the destination, maps the clipped region into
// the source for the selected rotation and picks the per-axis scale factors.
// ----------------------------------------------------------------------------
module brcrs_front
   import brcrs_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  rot_type                          rotation,
   input  logic                             scale_enable,
   input  logic [COORD_BITS-1:0]            scissor_left,
   input  logic [COORD_BITS-1:0]            scissor_top,
   input  logic [COORD_BITS-1:0]            scissor_right,
   input  logic [COORD_BITS-1:0]            scissor_bottom,
   input  logic [COORD_BITS-1:0]            dst_left,
   input  logic [COORD_BITS-1:0]            dst_top,
   input  logic [COORD_BITS-1:0]            dst_right,
   input  logic [COORD_BITS-1:0]            dst_bottom,
   input  logic [COORD_BITS-1:0]            src_left,
   input  logic [COORD_BITS-1:0]            src_top,
   input  logic [COORD_BITS-1:0]            src_right,
   input  logic [COORD_BITS-1:0]            src_bottom,
   output logic [entry_bits(COORD_BITS)-1:0] entry
);

   localparam int CB = COORD_BITS;
   localparam int SB = CB + 2;

   typedef struct packed {
      logic [CB-1:0]        cl;
      logic [CB-1:0]        ct;
      logic [CB-1:0]        cr;
      logic [CB-1:0]        cb;
      logic [CB:0]          dw_m1;
      logic [CB:0]          dh_m1;
      logic signed [SB-1:0] sx;
      logic signed [SB-1:0] w;
      logic signed [SB-1:0] sy;
      logic signed [SB-1:0] h;
      logic signed [CB:0]   num_x;
      logic signed [CB:0]   den_x;
      logic signed [CB:0]   num_y;
      logic signed [CB:0]   den_y;
   } entry_type;

   function automatic logic signed [SB-1:0] ext(input logic [CB-1:0] v);
      return $signed({2'b00, v});
   endfunction

   entry_type            e;
   logic [CB-1:0]        cl, ct, cr, cb;
   logic signed [SB-1:0] sx, sy, w, h, wd, hd, nx, ny, dwm, dhm;
   logic                 sc_x, sc_y;

   always_comb begin
      cl = (scissor_left > dst_left) ? scissor_left : dst_left;
      ct = (scissor_top > dst_top) ? scissor_top : dst_top;
      cr = (scissor_right < dst_right) ? scissor_right : dst_right;
      cb = (scissor_bottom < dst_bottom) ? scissor_bottom : dst_bottom;
      nx = ext(src_right) - ext(src_left);
      ny = ext(src_bottom) - ext(src_top);
      dwm = ext(cr) - ext(cl) - SB'(1);
      dhm = ext(cb) - ext(ct) - SB'(1);
      case (rotation)
         ROT_90: begin
            sx = ext(ct) - ext(dst_top) + ext(src_top);
            sy = ext(dst_right) - ext(cr) + ext(src_left);
            w  = ext(cb) - ext(ct);
            h  = ext(cr) - ext(cl);
            wd = ext(dst_bottom) - ext(dst_top);
            hd = ext(dst_right) - ext(dst_left);
         end
         ROT_180: begin
            sx = ext(dst_right) - ext(cr) + ext(src_left);
            sy = ext(dst_bottom) - ext(cb) + ext(src_top);
            w  = ext(cr) - ext(cl);
            h  = ext(cb) - ext(ct);
            wd = ext(dst_right) - ext(dst_left);
            hd = ext(dst_bottom) - ext(dst_top);
         end
         ROT_270: begin
            sx = ext(dst_bottom) - ext(cb) + ext(src_top);
            sy = ext(cl) - ext(dst_left) + ext(src_left);
            w  = ext(cb) - ext(ct);
            h  = ext(cr) - ext(cl);
            wd = ext(dst_bottom) - ext(dst_top);
            hd = ext(dst_right) - ext(dst_left);
         end
         default: begin
            sx = ext(cl) - ext(dst_left) + ext(src_left);
            sy = ext(ct) - ext(dst_top) + ext(src_top);
            w  = ext(cr) - ext(cl);
            h  = ext(cb) - ext(ct);
            wd = ext(dst_right) - ext(dst_left);
            hd = ext(dst_bottom) - ext(dst_top);
         end
      endcase
      // an axis left unscaled goes through the divider as times one over one
      sc_x = scale_enable && (nx != wd) && (wd != '0);
      sc_y = scale_enable && (ny != hd) && (hd != '0);
      e.cl    = cl;
      e.ct    = ct;
      e.cr    = cr;
      e.cb    = cb;
      e.dw_m1 = dwm[CB:0];
      e.dh_m1 = dhm[CB:0];
      e.sx    = sx;
      e.w     = w;
      e.sy    = sy;
      e.h     = h;
      e.num_x = sc_x ? nx[CB:0] : (CB+1)'(1);
      e.den_x = sc_x ? wd[CB:0] : (CB+1)'(1);
      e.num_y = sc_y ? ny[CB:0] : (CB+1)'(1);
      e.den_y = sc_y ? hd[CB:0] : (CB+1)'(1);
   end

   assign entry = e;

endmodule

// ===== rtl/brcrs_queue.sv =====
// ----------------------------------------------------------------------------
// brcrs_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module brcrs_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);

   localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NB = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [0:DEPTH-1];
   logic [PB-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NB-1:0]        count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != NB'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PB'(DEPTH - 1)) ? '0 : wr_ptr_ff + PB'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PB'(DEPTH - 1)) ? '0 : rd_ptr_ff + PB'(1);
      end
      count_in = count_ff + NB'(push) - NB'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/brcrs_back.sv =====
// ----------------------------------------------------------------------------
// brcrs_back
// Scales the mapped source start and size: product stage, a restoring
// divider pipeline of one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module brcrs_back
   import brcrs_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [entry_bits(COORD_BITS)-1:0] in_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [COORD_BITS-1:0]            rsp_out_dst_x,
   output logic [COORD_BITS-1:0]            rsp_out_dst_y,
   output logic signed [COORD_BITS:0]       rsp_out_dst_w_m1,
   output logic signed [COORD_BITS:0]       rsp_out_dst_h_m1,
   output logic [COORD_BITS-1:0]            rsp_out_src_x,
   output logic [COORD_BITS-1:0]            rsp_out_src_y,
   output logic signed [COORD_BITS:0]       rsp_out_src_w_m1,
   output logic signed [COORD_BITS:0]       rsp_out_src_h_m1,
   output logic [COORD_BITS-1:0]            rsp_clip_x1,
   output logic [COORD_BITS-1:0]            rsp_clip_y1,
   output logic [COORD_BITS-1:0]            rsp_clip_x2,
   output logic [COORD_BITS-1:0]            rsp_clip_y2
);

   localparam int CB = COORD_BITS;
   localparam int SB = CB + 2;
   localparam int PW = 2 * CB + 3;
   localparam int NB = 2 * CB + 1;
   localparam int LANES = 4;

   typedef struct packed {
      logic [CB-1:0]        cl;
      logic [CB-1:0]        ct;
      logic [CB-1:0]        cr;
      logic [CB-1:0]        cb;
      logic [CB:0]          dw_m1;
      logic [CB:0]          dh_m1;
      logic signed [SB-1:0] sx;
      logic signed [SB-1:0] w;
      logic signed [SB-1:0] sy;
      logic signed [SB-1:0] h;
      logic signed [CB:0]   num_x;
      logic signed [CB:0]   den_x;
      logic signed [CB:0]   num_y;
      logic signed [CB:0]   den_y;
   } entry_type;

   typedef struct packed {
      logic [CB-1:0] cl;
      logic [CB-1:0] ct;
      logic [CB-1:0] cr;
      logic [CB-1:0] cb;
      logic [CB:0]   dw_m1;
      logic [CB:0]   dh_m1;
   } side_type;

   entry_type            e;
   logic                 adv;
   logic                 vld_ff [0:NB];
   side_type             side_ff [0:NB];
   logic [NB-1:0]        nq_ff  [0:NB][0:LANES-1];
   logic [CB-1:0]        rem_ff [0:NB][0:LANES-1];
   logic [CB-1:0]        dv_ff  [0:NB][0:LANES-1];
   logic                 neg_ff [0:NB][0:LANES-1];
   logic signed [SB-1:0] lx  [0:LANES-1];
   logic signed [CB:0]   lnum [0:LANES-1];
   logic signed [CB:0]   lden [0:LANES-1];
   logic signed [PW-1:0] prod [0:LANES-1];
   logic signed [PW-1:0] pmag [0:LANES-1];
   logic signed [CB:0]   dmag [0:LANES-1];
   logic [CB:0]          t    [1:NB][0:LANES-1];
   logic                 ge   [1:NB][0:LANES-1];
   logic signed [NB+1:0] val  [0:LANES-1];

   logic                 out_v_ff;
   logic [CB-1:0]        dx_ff, dy_ff, sx_ff, sy_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [CB:0]          dw_ff, dh_ff, sw_ff, sh_ff;

   function automatic logic [CB-1:0] sat_pos(input logic signed [NB+1:0] v);
      if (v < 0) begin
         return '0;
      end else if (v > $signed((NB+2)'({CB{1'b1}}))) begin
         return {CB{1'b1}};
      end else begin
         return v[CB-1:0];
      end
   endfunction

   function automatic logic [CB:0] sat_size(input logic signed [NB+1:0] v);
      logic signed [NB+1:0] m1;
      m1 = v - (NB+2)'(1);
      if (m1 < -$signed((NB+2)'({1'b1, {CB{1'b0}}}))) begin
         return {1'b1, {CB{1'b0}}};
      end else if (m1 > $signed((NB+2)'({CB{1'b1}}))) begin
         return {1'b0, {CB{1'b1}}};
      end else begin
         return m1[CB:0];
      end
   endfunction

   assign e        = in_data;
   assign adv      = !out_v_ff || rsp_ready;
   assign in_ready = adv;

   always_comb begin
      lx[0] = e.sx;
      lx[1] = e.w;
      lx[2] = e.sy;
      lx[3] = e.h;
      lnum[0] = e.num_x;
      lnum[1] = e.num_x;
      lnum[2] = e.num_y;
      lnum[3] = e.num_y;
      lden[0] = e.den_x;
      lden[1] = e.den_x;
      lden[2] = e.den_y;
      lden[3] = e.den_y;
      for (int l = 0; l < LANES; l++) begin
         prod[l] = PW'(lx[l]) * PW'(lnum[l]);
         pmag[l] = prod[l][PW-1] ? -prod[l] : prod[l];
         dmag[l] = lden[l][CB] ? -lden[l] : lden[l];
      end
      // one restoring step per stage, quotient bits shift in at the bottom
      for (int k = 1; k <= NB; k++) begin
         for (int l = 0; l < LANES; l++) begin
            t[k][l]  = {rem_ff[k-1][l], nq_ff[k-1][l][NB-1]};
            ge[k][l] = (t[k][l] >= {1'b0, dv_ff[k-1][l]});
         end
      end
      for (int l = 0; l < LANES; l++) begin
         val[l] = neg_ff[NB][l] ? -$signed({2'b00, nq_ff[NB][l]})
                                : $signed({2'b00, nq_ff[NB][l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NB; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= NB; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_v_ff <= vld_ff[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{cl: e.cl, ct: e.ct, cr: e.cr, cb: e.cb,
                         dw_m1: e.dw_m1, dh_m1: e.dh_m1};
         for (int l = 0; l < LANES; l++) begin
            nq_ff[0][l]  <= pmag[l][NB-1:0];
            rem_ff[0][l] <= '0;
            dv_ff[0][l]  <= dmag[l][CB-1:0];
            neg_ff[0][l] <= prod[l][PW-1] ^ lden[l][CB];
         end
         for (int k = 1; k <= NB; k++) begin
            side_ff[k] <= side_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               nq_ff[k][l]  <= {nq_ff[k-1][l][NB-2:0], ge[k][l]};
               rem_ff[k][l] <= ge[k][l] ? CB'(t[k][l] - {1'b0, dv_ff[k-1][l]})
                                        : t[k][l][CB-1:0];
               dv_ff[k][l]  <= dv_ff[k-1][l];
               neg_ff[k][l] <= neg_ff[k-1][l];
            end
         end
         dx_ff <= side_ff[NB].cl;
         dy_ff <= side_ff[NB].ct;
         dw_ff <= side_ff[NB].dw_m1;
         dh_ff <= side_ff[NB].dh_m1;
         x1_ff <= side_ff[NB].cl;
         y1_ff <= side_ff[NB].ct;
         x2_ff <= side_ff[NB].cr;
         y2_ff <= side_ff[NB].cb;
         sx_ff <= sat_pos(val[0]);
         sw_ff <= sat_size(val[1]);
         sy_ff <= sat_pos(val[2]);
         sh_ff <= sat_size(val[3]);
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_out_dst_x    = dx_ff;
   assign rsp_out_dst_y    = dy_ff;
   assign rsp_out_dst_w_m1 = $signed(dw_ff);
   assign rsp_out_dst_h_m1 = $signed(dh_ff);
   assign rsp_out_src_x    = sx_ff;
   assign rsp_out_src_y    = sy_ff;
   assign rsp_out_src_w_m1 = $signed(sw_ff);
   assign rsp_out_src_h_m1 = $signed(sh_ff);
   assign rsp_clip_x1      = x1_ff;
   assign rsp_clip_y1      = y1_ff;
   assign rsp_clip_x2      = x2_ff;
   assign rsp_clip_y2      = y2_ff;

endmodule

// ===== rtl/blit_rect_clip_rotate_scale.sv =====
// ----------------------------------------------------------------------------
// blit_rect_clip_rotate_scale
// Per clip rectangle: clipped destination, rotated and scaled source window.
// ----------------------------------------------------------------------------
// Usage: one item on the req_ channel carries a scissor, a destination and a
// source rectangle; one item comes back on the rsp_ channel with the clipped
// destination start and size minus one, the source start and size minus one
// after rotation mapping and scaling, and the clip window.
// The front clips and maps an item in the cycle it is taken and writes it to
// a QUEUE_DEPTH-entry queue (four by default). The back runs a product stage,
// a restoring divider of 2*COORD_BITS+1 stages (one quotient bit each, four
// lanes) and an output register; one item per cycle is sustained while
// rsp_ready is high. While rsp_ready is low with an item at the output, the
// back holds still and the queue fills; req_ready falls when it is full. Reset
// empties queue and pipeline and sets rotation to none with scaling on.
// Registers are written through the APB port at byte addresses 0 (rotation)
// and 4 (scale enable), by the user only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module blit_rect_clip_rotate_scale
   import brcrs_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [COORD_BITS-1:0]      req_scissor_left,
   input  logic [COORD_BITS-1:0]      req_scissor_top,
   input  logic [COORD_BITS-1:0]      req_scissor_right,
   input  logic [COORD_BITS-1:0]      req_scissor_bottom,
   input  logic [COORD_BITS-1:0]      req_dst_left,
   input  logic [COORD_BITS-1:0]      req_dst_top,
   input  logic [COORD_BITS-1:0]      req_dst_right,
   input  logic [COORD_BITS-1:0]      req_dst_bottom,
   input  logic [COORD_BITS-1:0]      req_src_left,
   input  logic [COORD_BITS-1:0]      req_src_top,
   input  logic [COORD_BITS-1:0]      req_src_right,
   input  logic [COORD_BITS-1:0]      req_src_bottom,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_out_dst_x,
   output logic [COORD_BITS-1:0]      rsp_out_dst_y,
   output logic signed [COORD_BITS:0] rsp_out_dst_w_m1,
   output logic signed [COORD_BITS:0] rsp_out_dst_h_m1,
   output logic [COORD_BITS-1:0]      rsp_out_src_x,
   output logic [COORD_BITS-1:0]      rsp_out_src_y,
   output logic signed [COORD_BITS:0] rsp_out_src_w_m1,
   output logic signed [COORD_BITS:0] rsp_out_src_h_m1,
   output logic [COORD_BITS-1:0]      rsp_clip_x1,
   output logic [COORD_BITS-1:0]      rsp_clip_y1,
   output logic [COORD_BITS-1:0]      rsp_clip_x2,
   output logic [COORD_BITS-1:0]      rsp_clip_y2
);

   localparam int EB = entry_bits(COORD_BITS);

   rot_type     rot_ff;
   logic        scale_ff;
   logic        wr_en;
   reg_idx_type wr_idx;
   logic [EB-1:0] f_entry, q_entry;
   logic          q_valid, q_ready;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = reg_idx_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff   <= ROT_0;
         scale_ff <= 1'b1;
      end else if (wr_en) begin
         case (wr_idx)
            REG_ROTATION: rot_ff   <= rot_type'(pwdata[1:0]);
            REG_SCALE:    scale_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         REG_ROTATION: prdata = {30'd0, rot_ff};
         REG_SCALE:    prdata = {31'd0, scale_ff};
         default:      prdata = '0;
      endcase
   end

   brcrs_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .rotation      (rot_ff),
      .scale_enable  (scale_ff),
      .scissor_left  (req_scissor_left),
      .scissor_top   (req_scissor_top),
      .scissor_right (req_scissor_right),
      .scissor_bottom(req_scissor_bottom),
      .dst_left      (req_dst_left),
      .dst_top       (req_dst_top),
      .dst_right     (req_dst_right),
      .dst_bottom    (req_dst_bottom),
      .src_left      (req_src_left),
      .src_top       (req_src_top),
      .src_right     (req_src_right),
      .src_bottom    (req_src_bottom),
      .entry         (f_entry)
   );

   brcrs_queue #(
      .DATA_BITS(EB),
      .DEPTH    (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_data  (f_entry),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_data (q_entry)
   );

   brcrs_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_data         (q_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_dst_x   (rsp_out_dst_x),
      .rsp_out_dst_y   (rsp_out_dst_y),
      .rsp_out_dst_w_m1(rsp_out_dst_w_m1),
      .rsp_out_dst_h_m1(rsp_out_dst_h_m1),
      .rsp_out_src_x   (rsp_out_src_x),
      .rsp_out_src_y   (rsp_out_src_y),
      .rsp_out_src_w_m1(rsp_out_src_w_m1),
      .rsp_out_src_h_m1(rsp_out_src_h_m1),
      .rsp_clip_x1     (rsp_clip_x1),
      .rsp_clip_y1     (rsp_clip_y1),
      .rsp_clip_x2     (rsp_clip_x2),
      .rsp_clip_y2     (rsp_clip_y2)
   );

endmodule
